[rtl/jse_pkg.sv]
package jse_pkg;

    // How one queued command is rendered by the back end.
    typedef enum logic [1:0] {
        JSE_PLAIN   = 2'd0,
        JSE_PAIR    = 2'd1,
        JSE_UNICODE = 2'd2,
        JSE_END     = 2'd3
    } jse_cls_t;

    // One command handed from the front end to the back end.
    typedef struct packed {
        jse_cls_t    cls;
        logic [7:0]  arg;
        logic [15:0] base;
        logic        we;
        logic [31:0] total;
    } jse_cmd_t;

    localparam int JSE_QUEUE_DEPTH = 4;
    localparam int JSE_PTR_W       = $clog2(JSE_QUEUE_DEPTH);

    localparam logic [7:0] JSE_CH_QUOTE   = 8'h22;
    localparam logic [7:0] JSE_CH_SLASH   = 8'h2F;
    localparam logic [7:0] JSE_CH_BSLASH  = 8'h5C;
    localparam logic [7:0] JSE_CH_ZERO    = 8'h30;
    localparam logic [7:0] JSE_CH_B       = 8'h62;
    localparam logic [7:0] JSE_CH_F       = 8'h66;
    localparam logic [7:0] JSE_CH_N       = 8'h6E;
    localparam logic [7:0] JSE_CH_R       = 8'h72;
    localparam logic [7:0] JSE_CH_T       = 8'h74;
    localparam logic [7:0] JSE_CH_U       = 8'h75;
    localparam logic [7:0] JSE_CC_BS      = 8'h08;
    localparam logic [7:0] JSE_CC_TAB     = 8'h09;
    localparam logic [7:0] JSE_CC_LF      = 8'h0A;
    localparam logic [7:0] JSE_CC_FF      = 8'h0C;
    localparam logic [7:0] JSE_CC_CR      = 8'h0D;
    localparam logic [7:0] JSE_CTRL_LIMIT = 8'h20;
    localparam logic [7:0] JSE_HEX_ALPHA  = 8'h57;

    // Number of output bytes a command produces.
    function automatic logic [2:0] jse_seq_len(input jse_cls_t cls);
        logic [2:0] len;
        case (cls)
            JSE_PAIR:    len = 3'd2;
            JSE_UNICODE: len = 3'd6;
            default:     len = 3'd1;
        endcase
        return len;
    endfunction

    // Lowercase hex digit for a nibble.
    function automatic logic [7:0] jse_hex_digit(input logic [3:0] nib);
        logic [7:0] digit;
        if (nib < 4'd10)
        begin
            digit = JSE_CH_ZERO + {4'd0, nib};
        end
        else
        begin
            digit = JSE_HEX_ALPHA + {4'd0, nib};
        end
        return digit;
    endfunction

endpackage

[rtl/jse_front.sv]
module jse_front
    import jse_pkg::*;
#(
    parameter int CAP_W  = 16,
    parameter int NEED_W = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_action,
    input  logic [7:0]  in_char,
    input  logic        q_full,
    output logic        q_push,
    output jse_cmd_t    q_cmd
);

    logic [CAP_W-1:0]  cap_reg;
    logic [CAP_W-1:0]  pos_reg;
    logic [CAP_W-1:0]  pos_next;
    logic [NEED_W-1:0] need_reg;
    logic [NEED_W-1:0] need_next;
    jse_cls_t          cls;
    logic [7:0]        arg;
    logic [2:0]        len;
    logic [CAP_W:0]    pos_sum;
    logic              fits;
    logic [NEED_W:0]   need_sum;
    logic              accept;
    logic [CAP_W-1:0]  end_index;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Sort the byte into its escape class.
    always_comb
    begin
        cls = JSE_PLAIN;
        arg = in_char;
        if (in_char inside {JSE_CH_QUOTE, JSE_CH_BSLASH, JSE_CH_SLASH})
        begin
            cls = JSE_PAIR;
        end
        else
        begin
            case (in_char)
                JSE_CC_BS:
                begin
                    cls = JSE_PAIR;
                    arg = JSE_CH_B;
                end
                JSE_CC_FF:
                begin
                    cls = JSE_PAIR;
                    arg = JSE_CH_F;
                end
                JSE_CC_LF:
                begin
                    cls = JSE_PAIR;
                    arg = JSE_CH_N;
                end
                JSE_CC_CR:
                begin
                    cls = JSE_PAIR;
                    arg = JSE_CH_R;
                end
                JSE_CC_TAB:
                begin
                    cls = JSE_PAIR;
                    arg = JSE_CH_T;
                end
                default:
                begin
                    if (in_char < JSE_CTRL_LIMIT)
                    begin
                        cls = JSE_UNICODE;
                    end
                end
            endcase
        end
    end

    assign len      = jse_seq_len(cls);
    assign pos_sum  = {1'b0, pos_reg} + {{(CAP_W - 2){1'b0}}, len};
    assign fits     = pos_sum < {1'b0, cap_reg};
    assign need_sum = {1'b0, need_reg} + {{(NEED_W - 2){1'b0}}, len};

    // The terminator lands at the last buffer slot if the capacity was lowered.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            end_index = '0;
        end
        else if (pos_reg < cap_reg)
        begin
            end_index = pos_reg;
        end
        else
        begin
            end_index = cap_reg - 1'b1;
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        need_next = need_reg;
        q_push    = 1'b0;
        q_cmd     = '0;
        if (in_action)
        begin
            q_cmd.cls   = JSE_END;
            q_cmd.arg   = '0;
            q_cmd.base  = 16'(end_index);
            q_cmd.we    = (cap_reg != '0);
            q_cmd.total = 32'(need_reg);
            q_push      = accept;
            if (accept)
            begin
                pos_next  = '0;
                need_next = '0;
            end
        end
        else
        begin
            q_cmd.cls   = cls;
            q_cmd.arg   = arg;
            q_cmd.base  = 16'(pos_reg);
            q_cmd.we    = 1'b1;
            q_cmd.total = '0;
            q_push      = accept && fits;
            if (accept)
            begin
                need_next = need_sum[NEED_W] ? '1 : need_sum[NEED_W-1:0];
                if (fits)
                begin
                    pos_next = pos_sum[CAP_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= '0;
            pos_reg  <= '0;
            need_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata[CAP_W-1:0];
            end
            pos_reg  <= pos_next;
            need_reg <= need_next;
        end
    end

endmodule

[rtl/jse_queue.sv]
module jse_queue
    import jse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  jse_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output jse_cmd_t head_cmd,
    output logic     empty
);

    jse_cmd_t             slot_reg [JSE_QUEUE_DEPTH];
    logic [JSE_PTR_W-1:0] wr_ptr_reg;
    logic [JSE_PTR_W-1:0] wr_ptr_next;
    logic [JSE_PTR_W-1:0] rd_ptr_reg;
    logic [JSE_PTR_W-1:0] rd_ptr_next;
    logic [JSE_PTR_W:0]   count_reg;
    logic [JSE_PTR_W:0]   count_next;

    assign full     = (count_reg == (JSE_PTR_W + 1)'(JSE_QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command popped from an empty queue");
`endif

endmodule

[rtl/jse_back.sv]
module jse_back
    import jse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  jse_cmd_t    q_cmd,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [15:0] out_index,
    output logic        out_we,
    output logic        out_is_end,
    output logic [31:0] out_total,
    output logic        out_last
);

    logic        cur_valid_reg;
    logic        cur_valid_next;
    jse_cmd_t    cur_reg;
    jse_cmd_t    cur_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  byte_reg;
    logic [15:0] index_reg;
    logic        we_reg;
    logic        is_end_reg;
    logic [31:0] total_reg;
    logic        last_reg;
    logic        load_out;
    logic        advance;
    logic        cur_final;
    logic        frees;
    logic [7:0]  gen_byte;

    assign load_out  = !out_valid_reg || out_ready;
    assign advance   = load_out && cur_valid_reg;
    assign cur_final = (cnt_reg == jse_seq_len(cur_reg.cls) - 3'd1);
    assign frees     = !cur_valid_reg || (advance && cur_final);
    assign q_pop     = frees && !q_empty;

    always_comb
    begin
        cur_valid_next = frees ? !q_empty : cur_valid_reg;
        cur_next       = q_pop ? q_cmd : cur_reg;
        if (frees)
        begin
            cnt_next = '0;
        end
        else if (advance)
        begin
            cnt_next = cnt_reg + 3'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
        out_valid_next = load_out ? cur_valid_reg : out_valid_reg;
    end

    // Byte number cnt_reg of the current escape sequence.
    always_comb
    begin
        case (cur_reg.cls)
            JSE_PLAIN:
            begin
                gen_byte = cur_reg.arg;
            end
            JSE_PAIR:
            begin
                gen_byte = (cnt_reg == 3'd0) ? JSE_CH_BSLASH : cur_reg.arg;
            end
            JSE_UNICODE:
            begin
                case (cnt_reg)
                    3'd0:    gen_byte = JSE_CH_BSLASH;
                    3'd1:    gen_byte = JSE_CH_U;
                    3'd4:    gen_byte = jse_hex_digit(cur_reg.arg[7:4]);
                    3'd5:    gen_byte = jse_hex_digit(cur_reg.arg[3:0]);
                    default: gen_byte = JSE_CH_ZERO;
                endcase
            end
            default:
            begin
                gen_byte = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (advance)
        begin
            byte_reg   <= gen_byte;
            index_reg  <= cur_reg.base + {13'd0, cnt_reg};
            we_reg     <= cur_reg.we;
            is_end_reg <= (cur_reg.cls == JSE_END);
            total_reg  <= cur_reg.total;
            last_reg   <= cur_final;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign out_index  = index_reg;
    assign out_we     = we_reg;
    assign out_is_end = is_end_reg;
    assign out_total  = total_reg;
    assign out_last   = last_reg;

`ifndef SYNTH
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_end_reg |-> last_reg)
        else $error("terminator transaction not marked last");

    a_body_written: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !is_end_reg |-> we_reg && (total_reg == '0))
        else $error("string byte with write enable low or a nonzero total");
`endif

endmodule

[rtl/json_string_escaper_top.sv]
// JSON string escaper. Each input transaction carries one string byte
// (tuser low) or an end-of-string mark (tuser high). The block emits the
// escaped form one destination byte per output transaction, each tagged with
// its buffer index: quote, backslash and slash become a backslash pair, the
// five common control codes become backslash plus b, f, n, r or t, any other
// byte below 0x20 becomes a six-byte backslash-u escape with lowercase hex,
// and everything else passes through. A sequence is written only when it
// fits with room left for the terminator; a sequence that does not fit gives
// no output at all, yet still counts in the needed length, which saturates.
// An end mark gives one transaction with the NUL terminator and the needed
// total, then clears the position and the count. Write the capacity through
// cfg_we/cfg_wdata while the block is idle. Plain bytes stream at one per
// cycle while the output is not stalled, through a queue slot, the current
// command register and the output register; a two-byte escape occupies the
// output for two transactions and a backslash-u escape for six, and a
// four-entry command queue between the classifying front end and the
// byte-generating back end absorbs that, so the input only stalls once full.
module json_string_escaper_top
    import jse_pkg::*;
#(
    parameter int CAPACITY_BITS = 16,
    parameter int NEEDED_BITS   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // out_capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tuser,   // [0] action: 1 marks end of string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [7:0] out_byte, [23:8] out_index,
                                        // [55:24] needed_total
    output logic [1:0]  m_axis_tuser,   // [0] write_enable, [1] is_end
    output logic        m_axis_tlast    // last transaction for this input
);

    // Only the low CAPACITY_BITS of the 16-bit capacity are kept.
    localparam int CAP_W = (CAPACITY_BITS < 16) ? CAPACITY_BITS : 16;

    logic        q_push;
    jse_cmd_t    q_push_cmd;
    logic        q_full;
    logic        q_pop;
    jse_cmd_t    q_head_cmd;
    logic        q_empty;
    logic [7:0]  out_byte;
    logic [15:0] out_index;
    logic        out_we;
    logic        out_is_end;
    logic [31:0] out_total;

    // The front end owns the capacity, the write position and the needed
    // count; it decides at accept time whether a sequence fits.
    jse_front #(
        .CAP_W  (CAP_W),
        .NEED_W (NEEDED_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_char   (s_axis_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    jse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (q_head_cmd),
        .empty    (q_empty)
    );

    // The back end expands each command into its bytes behind a registered
    // output stage.
    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_cmd      (q_head_cmd),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (out_byte),
        .out_index  (out_index),
        .out_we     (out_we),
        .out_is_end (out_is_end),
        .out_total  (out_total),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_total, out_index, out_byte};
    assign m_axis_tuser = {out_is_end, out_we};

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for the JSON string escaper. String bytes and end-of-string marks
// are queued by the stimulus process and offered by a driver that idles at
// random. A monitor sees every accepted transaction on both sides. For each
// accepted input it runs an escaper model and queues the destination bytes
// that the block must produce. Each output transaction is then checked
// against the oldest of those bytes.
module tb_top
    import jse_pkg::*;
();

    // Input transaction codes carried in tuser.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam int IDLE_PCT       = 36;
    localparam int SETTLE_CYCLES  = 40;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 24;
    localparam logic [127:0] HEX_DIGITS = "0123456789abcdef";

    // One pending input transaction.
    typedef struct {
        logic       action;
        logic [7:0] ch;
    } str_item_t;

    // One destination byte the block is expected to emit.
    typedef struct {
        logic [7:0]  data;
        logic [15:0] index;
        logic        wr_en;
        logic        is_end;
        logic [31:0] total;
        logic        tail;
    } dest_byte_t;

    logic        clk = 1'b1;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;      // [7:0] char_byte
    logic        s_axis_tuser = 1'b0;      // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;             // [7:0] out_byte, [23:8] out_index,
                                           // [55:24] needed_total
    logic [1:0]  m_axis_tuser;             // [0] write_enable, [1] is_end
    logic        m_axis_tlast;             // last transaction for this input

    // Model state: the capacity register, the next free buffer index and the
    // running escaped length.
    logic [15:0] cap_reg = 16'd0;
    logic [15:0] wr_pos = 16'd0;
    logic [31:0] need_cnt = 32'd0;

    str_item_t  string_items[$];
    dest_byte_t expected_bytes[$];
    dest_byte_t want;

    // Handshake bookkeeping between the monitor (rising edge) and the driver
    // (falling edge).
    bit char_taken = 1'b0;
    bit offering = 1'b0;
    bit calm = 1'b0;
    int fail_count = 0;
    int cycle_count = 0;

    json_string_escaper_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Escape one accepted input and queue the destination bytes it yields.
    // A byte whose whole sequence does not leave room for the terminator
    // yields nothing, but it still adds to the needed length.
    task automatic escape_char(input logic act, input logic [7:0] ch);
        jse_cls_t   cls;
        logic [7:0] seq [6];
        logic [7:0] second;
        int         len;
        dest_byte_t r;

        r.data   = 8'h00;
        r.index  = 16'd0;
        r.wr_en  = 1'b0;
        r.is_end = 1'b0;
        r.total  = 32'd0;
        r.tail   = 1'b0;
        if (act == ACT_END)
        begin
            // With zero capacity nothing may be stored. A position at or past
            // the capacity (capacity lowered mid-string) puts the terminator
            // in the last slot of the buffer.
            if (cap_reg != 16'd0)
            begin
                r.wr_en = 1'b1;
                r.index = (wr_pos < cap_reg) ? wr_pos : cap_reg - 16'd1;
            end
            r.is_end = 1'b1;
            r.total  = need_cnt;
            r.tail   = 1'b1;
            expected_bytes.push_back(r);
            wr_pos   = 16'd0;
            need_cnt = 32'd0;
        end
        else
        begin
            cls    = JSE_PAIR;
            second = ch;
            case (ch)
                JSE_CH_QUOTE, JSE_CH_BSLASH, JSE_CH_SLASH: second = ch;
                JSE_CC_BS:  second = JSE_CH_B;
                JSE_CC_FF:  second = JSE_CH_F;
                JSE_CC_LF:  second = JSE_CH_N;
                JSE_CC_CR:  second = JSE_CH_R;
                JSE_CC_TAB: second = JSE_CH_T;
                default:    cls = (ch < JSE_CTRL_LIMIT) ? JSE_UNICODE : JSE_PLAIN;
            endcase
            for (int k = 0; k < 6; k++)
            begin
                seq[k] = 8'h00;
            end
            case (cls)
                JSE_PLAIN:
                begin
                    seq[0] = ch;
                    len = 1;
                end
                JSE_PAIR:
                begin
                    seq[0] = JSE_CH_BSLASH;
                    seq[1] = second;
                    len = 2;
                end
                default:
                begin
                    seq[0] = JSE_CH_BSLASH;
                    seq[1] = JSE_CH_U;
                    seq[2] = JSE_CH_ZERO;
                    seq[3] = JSE_CH_ZERO;
                    seq[4] = HEX_DIGITS[8 * (15 - int'(ch[7:4])) +: 8];
                    seq[5] = HEX_DIGITS[8 * (15 - int'(ch[3:0])) +: 8];
                    len = 6;
                end
            endcase

            // The needed length saturates instead of wrapping.
            if (need_cnt > 32'hFFFF_FFFF - 32'(len))
            begin
                need_cnt = 32'hFFFF_FFFF;
            end
            else
            begin
                need_cnt = need_cnt + 32'(len);
            end

            if (int'(wr_pos) + len < int'(cap_reg))
            begin
                for (int k = 0; k < len; k++)
                begin
                    r.data  = seq[k];
                    r.index = wr_pos + 16'(k);
                    r.wr_en = 1'b1;
                    r.tail  = (k == len - 1);
                    expected_bytes.push_back(r);
                end
                wr_pos = wr_pos + 16'(len);
            end
        end
    endtask

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    // Monitor: everything is sampled at the rising edge, while the inputs
    // only move at the falling edge.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                escape_char(s_axis_tuser, s_axis_tdata);
                char_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected output transaction: byte 0x%0h index %0d",
                           m_axis_tdata[7:0], m_axis_tdata[23:8]);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    check_field("out_byte", 32'(want.data), 32'(m_axis_tdata[7:0]));
                    check_field("out_index", 32'(want.index), 32'(m_axis_tdata[23:8]));
                    check_field("needed_total", want.total, m_axis_tdata[55:24]);
                    check_field("write_enable", 32'(want.wr_en), 32'(m_axis_tuser[0]));
                    check_field("is_end", 32'(want.is_end), 32'(m_axis_tuser[1]));
                    check_field("last", 32'(want.tail), 32'(m_axis_tlast));
                end
            end
        end
    end

    // Driver: offers the oldest pending item and holds it until the block
    // takes it. A new offer may be delayed at random, never withdrawn.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (char_taken)
            begin
                void'(string_items.pop_front());
                char_taken = 1'b0;
                offering = 1'b0;
            end
            if (!offering && string_items.size() != 0 &&
                (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                offering = 1'b1;
                s_axis_tdata <= string_items[0].ch;
                s_axis_tuser <= string_items[0].action;
            end
            s_axis_tvalid <= offering;
        end
    end

    // The output side stalls at random too, except during the calm phase.
    always @(negedge clk)
    begin
        m_axis_tready <= rst_n && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send(input logic act, input logic [7:0] ch);
        str_item_t it;
        it.action = act;
        it.ch = ch;
        string_items.push_back(it);
    endtask

    // Wait until every queued item has been taken and every expected byte has
    // arrived, then give a byte that yields no output time to leave the pipe.
    task automatic drain();
        while (string_items.size() != 0 || offering || expected_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The capacity is only written while the block is idle.
    task automatic set_capacity(input logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cap_reg = value;
    endtask

    // Random character, weighted toward the bytes that need escaping.
    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = 8'($urandom_range(0, 255));
            1:
            begin
                case ($urandom_range(0, 7))
                    0: c = JSE_CH_QUOTE;
                    1: c = JSE_CH_BSLASH;
                    2: c = JSE_CH_SLASH;
                    3: c = JSE_CC_BS;
                    4: c = JSE_CC_FF;
                    5: c = JSE_CC_LF;
                    6: c = JSE_CC_CR;
                    default: c = JSE_CC_TAB;
                endcase
            end
            2: c = 8'($urandom_range(0, 31));
            default: c = 8'($urandom_range(32, 126));
        endcase
        return c;
    endfunction

    initial
    begin
        logic [15:0] caps [RANDOM_PHASES];

        caps = '{16'd65535, 16'd200, 16'd3, 16'd0, 16'd1, 16'd2, 16'd16,
                 16'd65535, 16'd7, 16'd0, 16'd0, 16'd64};
        caps[9]  = 16'($urandom_range(0, 65535));
        caps[10] = 16'($urandom_range(0, 80));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Capacity still at its reset value of zero: bytes never fit, and the
        // end mark must come back with the write enable low.
        send(ACT_BYTE, 8'h41);
        send(ACT_BYTE, 8'h00);
        send(ACT_END, 8'hFF);
        drain();

        // Largest buffer: every escape class and the byte extremes.
        set_capacity(16'd65535);
        send(ACT_BYTE, JSE_CH_QUOTE);
        send(ACT_BYTE, JSE_CH_BSLASH);
        send(ACT_BYTE, JSE_CH_SLASH);
        send(ACT_BYTE, JSE_CC_BS);
        send(ACT_BYTE, JSE_CC_FF);
        send(ACT_BYTE, JSE_CC_LF);
        send(ACT_BYTE, JSE_CC_CR);
        send(ACT_BYTE, JSE_CC_TAB);
        send(ACT_BYTE, 8'h00);
        send(ACT_BYTE, 8'h1F);
        send(ACT_BYTE, 8'h20);
        send(ACT_BYTE, 8'h7F);
        send(ACT_BYTE, 8'h80);
        send(ACT_BYTE, 8'hFF);
        send(ACT_END, 8'h00);
        drain();

        // A sequence that does not fit is skipped, while a shorter one after
        // it still goes in.
        set_capacity(16'd9);
        send(ACT_BYTE, 8'h61);
        send(ACT_BYTE, 8'h01);
        send(ACT_BYTE, JSE_CH_QUOTE);
        send(ACT_BYTE, 8'h62);
        send(ACT_END, 8'h00);
        drain();

        // Capacity lowered in mid-string below the write position: the
        // terminator lands in the last slot.
        set_capacity(16'd40);
        send(ACT_BYTE, 8'h78);
        send(ACT_BYTE, 8'h78);
        send(ACT_BYTE, 8'h1B);
        drain();
        set_capacity(16'd4);
        send(ACT_END, 8'h00);
        drain();

        // Random phases. A phase often stops in mid-string, so the next
        // capacity takes effect on a partly written buffer.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_capacity(caps[ph]);
            calm = (ph == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send(ACT_END, 8'($urandom_range(0, 255)));
                end
                else
                begin
                    send(ACT_BYTE, rand_char());
                end
            end
            drain();
        end

        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[json_string_escaper_top.f]
rtl/jse_pkg.sv
rtl/jse_front.sv
rtl/jse_queue.sv
rtl/jse_back.sv
rtl/json_string_escaper_top.sv
sim/tb_top.sv
